[sv/rei_pkg.sv]
// shared types, codes and tables for the rotary encoder interface
`timescale 1ns / 1ps
`default_nettype none

package rei_pkg;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_POLL   = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_CLICK = 3'd1;
  localparam logic [2:0] EV_LONG  = 3'd2;
  localparam logic [2:0] EV_LEFT  = 3'd3;
  localparam logic [2:0] EV_RIGHT = 3'd4;

  localparam logic signed [3:0] DETENT_POS = 4'sd4;
  localparam logic signed [3:0] DETENT_NEG = -4'sd4;

  localparam logic [1:0] QUAD_RST = 2'b01;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

  localparam int unsigned CFG_ADDR_W = 3;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic click;
    logic long_click;
  } sw_flags_t;

  function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    unique case (idx)
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
      default:                  d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[sv/rei_in_if.sv]
// request channel carrying pin samples, polls and reads
`timescale 1ns / 1ps
`default_nettype none

interface rei_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        quad_a;
  logic        quad_b;
  logic        button_pressed;
  logic [31:0] now_ms;

  modport source (output valid, mode, quad_a, quad_b, button_pressed, now_ms, input ready);
  modport sink   (input valid, mode, quad_a, quad_b, button_pressed, now_ms, output ready);
endinterface

`default_nettype wire

[sv/rei_out_if.sv]
// result channel carrying event code and tick total
`timescale 1ns / 1ps
`default_nettype none

interface rei_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic signed [15:0] tick_total;

  modport source (output valid, event_res, tick_total, input ready);
  modport sink   (input valid, event_res, tick_total, output ready);
endinterface

`default_nettype wire

[sv/rei_cfg_regs.sv]
// apb-style configuration registers for debounce and long-press limits
`timescale 1ns / 1ps
`default_nettype none

module rei_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rei_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  output rei_pkg::cfg_t                        cfg
);

  rei_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= rei_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms <= rei_pkg::LONG_PRESS_RST;
    end else if (wr_en) begin
      if (paddr[2]) begin
        cfg_r.long_press_ms <= pwdata[15:0];
      end else begin
        cfg_r.debounce_ms <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {16'd0, cfg_r.long_press_ms};
    end else begin
      prdata = {16'd0, cfg_r.debounce_ms};
    end
  end

endmodule

`default_nettype wire

[sv/rei_quad.sv]
// quadrature decoder with detent accumulator and rotation count
`timescale 1ns / 1ps
`default_nettype none

module rei_quad (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        sample_en,
  input  wire logic        quad_a,
  input  wire logic        quad_b,
  input  wire logic        rot_clr,
  output logic [15:0]      rot_count
);

  logic [1:0]        prev_r;
  logic signed [3:0] acc_r;
  logic [15:0]       rot_r;

  logic [1:0]        cur;
  logic signed [1:0] delta;
  logic signed [3:0] acc_sum;
  logic signed [3:0] acc_nxt;
  logic [15:0]       rot_nxt;

  assign cur       = {quad_a, quad_b};
  assign delta     = rei_pkg::quad_delta({prev_r, cur});
  assign acc_sum   = acc_r + {{2{delta[1]}}, delta};
  assign rot_count = rot_r;

  always_comb begin
    acc_nxt = acc_sum;
    rot_nxt = rot_r;
    if (acc_sum == rei_pkg::DETENT_POS) begin
      acc_nxt = 4'sd0;
      rot_nxt = rot_r + 16'd1;
    end else if (acc_sum == rei_pkg::DETENT_NEG) begin
      acc_nxt = 4'sd0;
      rot_nxt = rot_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= rei_pkg::QUAD_RST;
      acc_r  <= 4'sd0;
      rot_r  <= 16'd0;
    end else if (sample_en) begin
      prev_r <= cur;
      acc_r  <= acc_nxt;
      rot_r  <= rot_nxt;
    end else if (rot_clr) begin
      rot_r <= 16'd0;
    end
  end

endmodule

`default_nettype wire

[sv/rei_switch.sv]
// time-gated switch debounce with click and long-click flags
`timescale 1ns / 1ps
`default_nettype none

module rei_switch (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               sample_en,
  input  wire logic               pressed,
  input  wire logic [31:0]        now_ms,
  input  wire rei_pkg::cfg_t      cfg,
  input  wire rei_pkg::sw_flags_t flag_clr,
  output rei_pkg::sw_flags_t      flags
);

  logic               deb_r;
  logic               raw_r;
  logic [31:0]        edge_time_r;
  rei_pkg::sw_flags_t flags_r;

  logic [31:0] elapsed;
  logic        changed;
  logic        accepted;

  assign elapsed  = now_ms - edge_time_r;
  assign changed  = sample_en && (pressed != raw_r);
  assign accepted = changed && (elapsed >= {16'd0, cfg.debounce_ms});
  assign flags    = flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r       <= 1'b0;
      raw_r       <= 1'b0;
      edge_time_r <= 32'd0;
      flags_r     <= '0;
    end else begin
      if (changed) begin
        raw_r <= pressed;
      end
      if (accepted) begin
        edge_time_r <= now_ms;
        if (pressed != deb_r) begin
          deb_r <= pressed;
          if (!pressed) begin
            if (elapsed > {16'd0, cfg.long_press_ms}) begin
              flags_r.long_click <= 1'b1;
            end else begin
              flags_r.click <= 1'b1;
            end
          end
        end
      end
      if (flag_clr.click) begin
        flags_r.click <= 1'b0;
      end
      if (flag_clr.long_click) begin
        flags_r.long_click <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/rotary_encoder_interface.sv]
// rotary encoder interface: usage
// in_ch carries one request per handshake: mode 0 is a pin sample (a/b levels,
// switch level, ms timestamp), mode 1 polls for an event, mode 2 reads and
// clears the tick total. out_ch returns exactly one result per request: event
// code and tick total. a request is registered into the input register on
// acceptance; its result goes into the output register once that is empty
// or being taken. one request per cycle is sustained while out_ch takes
// results; the limit is the single update of the decoder, debounce and tick
// registers per cycle. when out_ch stalls the result is held, one more
// request is taken into the input register, and in_ch.ready then drops until
// the result is taken. cfg_* is an apb-style port: debounce_ms at 0x0,
// long_press_ms at 0x4, written only while idle: a user rule, not enforced
// by the block. synchronous active-low reset clears all state but request
// and result data, loads defaults (50 ms and 1000 ms), empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_interface (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rei_in_if.sink                               in_ch,
  rei_out_if.source                            out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [rei_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  rei_pkg::cfg_t      cfg;
  rei_pkg::sw_flags_t sw_flags;
  rei_pkg::sw_flags_t sw_clr;

  logic        s1_valid_r;
  logic [1:0]  s1_mode_r;
  logic        s1_a_r;
  logic        s1_b_r;
  logic        s1_btn_r;
  logic [31:0] s1_now_r;
  logic        s1_fire;
  logic        in_fire;

  logic [15:0] rot_count;
  logic        rot_clr;
  logic        sample_en;

  logic [15:0] tick_r;
  logic [15:0] tick_nxt;
  logic [15:0] tick_sum;

  logic        out_valid_r;
  logic [2:0]  out_event_r;
  logic [15:0] out_tick_r;
  logic [2:0]  ev_nxt;
  logic [15:0] shown_nxt;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_res  = out_event_r;
  assign out_ch.tick_total = out_tick_r;

  rei_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rei_quad u_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .quad_a    (s1_a_r),
    .quad_b    (s1_b_r),
    .rot_clr   (rot_clr),
    .rot_count (rot_count)
  );

  rei_switch u_switch (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .pressed   (s1_btn_r),
    .now_ms    (s1_now_r),
    .cfg       (cfg),
    .flag_clr  (sw_clr),
    .flags     (sw_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_ch.mode;
      s1_a_r    <= in_ch.quad_a;
      s1_b_r    <= in_ch.quad_b;
      s1_btn_r  <= in_ch.button_pressed;
      s1_now_r  <= in_ch.now_ms;
    end
  end

  assign tick_sum = tick_r + rot_count;

  always_comb begin
    sample_en = 1'b0;
    rot_clr   = 1'b0;
    sw_clr    = '0;
    tick_nxt  = tick_r;
    ev_nxt    = rei_pkg::EV_NONE;
    shown_nxt = tick_r;
    if (s1_fire) begin
      unique case (s1_mode_r)
        rei_pkg::MODE_SAMPLE: begin
          sample_en = 1'b1;
        end
        rei_pkg::MODE_POLL: begin
          priority if (sw_flags.click) begin
            sw_clr.click = 1'b1;
            ev_nxt       = rei_pkg::EV_CLICK;
          end else if (sw_flags.long_click) begin
            sw_clr.long_click = 1'b1;
            ev_nxt            = rei_pkg::EV_LONG;
          end else begin
            tick_nxt  = tick_sum;
            shown_nxt = tick_sum;
            if (rot_count != 16'd0) begin
              rot_clr = 1'b1;
              ev_nxt  = tick_sum[15] ? rei_pkg::EV_LEFT : rei_pkg::EV_RIGHT;
            end
          end
        end
        rei_pkg::MODE_READ: begin
          tick_nxt = 16'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r <= tick_nxt;
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_event_r <= ev_nxt;
      out_tick_r  <= shown_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed request gave no result");

  a_click_first: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_mode_r == rei_pkg::MODE_POLL) && sw_flags.click)
      |=> (out_event_r == rei_pkg::EV_CLICK) && !sw_flags.click)
    else $error("pending click not reported and cleared");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_mode_r == rei_pkg::MODE_READ))
      |=> (tick_r == 16'd0) && (out_tick_r == $past(tick_r)))
    else $error("read did not return and clear tick total");
`endif

endmodule

`default_nettype wire

[sim/rotary_encoder_interface_checker.sv]
// checker for the rotary encoder interface: predicts every result and compares it
`timescale 1ns / 1ps

module rotary_encoder_interface_checker #(
  parameter logic [rei_pkg::CFG_ADDR_W-1:0] ADDR_DEBOUNCE   = 'h0,
  parameter logic [rei_pkg::CFG_ADDR_W-1:0] ADDR_LONG_PRESS = 'h4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rei_in_if                               in_mon,
  rei_out_if                              out_mon,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic                            cfg_pready,
  input  logic [rei_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output int                              fail_count,
  output int                              pending_results
);

  // step per {previous a/b, current a/b}
  localparam logic signed [1:0] QUAD_STEP [16] = '{
    2'sd0, -2'sd1,  2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0, -2'sd1,
   -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    logic [2:0]         ev;
    logic signed [15:0] tick;
  } result_t;

  result_t            expected_results[$];
  int                 mismatches = 0;
  int                 result_index = 0;

  logic [15:0]        cfg_debounce;
  logic [15:0]        cfg_long_press;
  logic [1:0]         last_ab;
  logic signed [3:0]  detent_acc;
  logic [15:0]        turns;
  logic [15:0]        tick_sum;
  logic               click_pending;
  logic               long_pending;
  logic               sw_stable;
  logic               sw_raw;
  logic [31:0]        edge_stamp;

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", result_index, msg);
    mismatches++;
  endtask

  function automatic result_t next_result(input logic [1:0] mode, input logic a, input logic b,
                                          input logic btn, input logic [31:0] stamp);
    result_t           r;
    logic [1:0]        ab;
    logic signed [4:0] acc;
    logic [31:0]       elapsed;
    r.ev = rei_pkg::EV_NONE;
    r.tick = tick_sum;
    case (mode)
      rei_pkg::MODE_SAMPLE: begin
        ab = {a, b};
        acc = detent_acc + QUAD_STEP[{last_ab, ab}];
        if (acc == rei_pkg::DETENT_POS) begin
          turns = turns + 16'd1;
          acc = '0;
        end else if (acc == rei_pkg::DETENT_NEG) begin
          turns = turns - 16'd1;
          acc = '0;
        end
        detent_acc = acc[3:0];
        last_ab = ab;
        if (btn != sw_raw) begin
          sw_raw = btn;
          elapsed = stamp - edge_stamp;
          if (elapsed >= {16'd0, cfg_debounce}) begin
            if (btn != sw_stable) begin
              sw_stable = btn;
              if (!btn) begin
                if (elapsed > {16'd0, cfg_long_press}) long_pending = 1'b1;
                else click_pending = 1'b1;
              end
            end
            edge_stamp = stamp;
          end
        end
        r.tick = tick_sum;
      end
      rei_pkg::MODE_POLL: begin
        if (click_pending) begin
          click_pending = 1'b0;
          r.ev = rei_pkg::EV_CLICK;
        end else if (long_pending) begin
          long_pending = 1'b0;
          r.ev = rei_pkg::EV_LONG;
        end else begin
          tick_sum = tick_sum + turns;
          if (turns != 16'd0) begin
            turns = '0;
            r.ev = tick_sum[15] ? rei_pkg::EV_LEFT : rei_pkg::EV_RIGHT;
          end
        end
        r.tick = tick_sum;
      end
      rei_pkg::MODE_READ: begin
        r.tick = tick_sum;
        tick_sum = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      expected_results.delete();
      cfg_debounce = rei_pkg::DEBOUNCE_RST;
      cfg_long_press = rei_pkg::LONG_PRESS_RST;
      last_ab = rei_pkg::QUAD_RST;
      detent_acc = '0;
      turns = '0;
      tick_sum = '0;
      click_pending = 1'b0;
      long_pending = 1'b0;
      sw_stable = 1'b0;
      sw_raw = 1'b0;
      edge_stamp = '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_DEBOUNCE) cfg_debounce = cfg_pwdata[15:0];
        else if (cfg_paddr == ADDR_LONG_PRESS) cfg_long_press = cfg_pwdata[15:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(next_result(in_mon.mode, in_mon.quad_a, in_mon.quad_b,
                                               in_mon.button_pressed, in_mon.now_ms));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("no request waiting, got event %0d tick %0d",
                                    out_mon.event_res, $signed(out_mon.tick_total)));
        end else begin
          want = expected_results.pop_front();
          if (out_mon.event_res !== want.ev)
            report_mismatch($sformatf("event expected %0d got %0d", want.ev, out_mon.event_res));
          if (out_mon.tick_total !== want.tick)
            report_mismatch($sformatf("tick total expected %0d got %0d",
                                      $signed(want.tick), $signed(out_mon.tick_total)));
        end
        result_index++;
      end
    end
    fail_count <= mismatches;
    pending_results <= expected_results.size();
  end

endmodule

[sim/rotary_encoder_interface_tb.sv]
// testbench top for the rotary encoder interface: stimulus, configuration and verdict
`timescale 1ns / 1ps

module rotary_encoder_interface_tb;

  localparam logic [rei_pkg::CFG_ADDR_W-1:0] ADDR_DEBOUNCE   = 'h0;
  localparam logic [rei_pkg::CFG_ADDR_W-1:0] ADDR_LONG_PRESS = 'h4;
  localparam logic [1:0]                     MODE_UNUSED     = 2'd3;
  localparam int                             ITEMS_PER_PHASE = 75;
  localparam int                             BURST_TURNS     = 8;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [rei_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]                    cfg_pwdata;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;
  int                             fail_count;
  int                             pending_results;

  bit                    in_idle_on = 1'b1;
  bit                    out_idle_on = 1'b1;
  logic [1:0]            pin_ab = rei_pkg::QUAD_RST;
  logic                  pin_btn = 1'b0;
  logic [31:0]           now_ms = '0;
  bit                    spin_cw = 1'b1;
  logic [15:0]           cur_debounce = rei_pkg::DEBOUNCE_RST;
  logic [15:0]           cur_long = rei_pkg::LONG_PRESS_RST;

  rei_in_if  in_ch ();
  rei_out_if out_ch ();

  rotary_encoder_interface u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  rotary_encoder_interface_checker #(
    .ADDR_DEBOUNCE   (ADDR_DEBOUNCE),
    .ADDR_LONG_PRESS (ADDR_LONG_PRESS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_request(input logic [1:0] mode, input logic a, input logic b,
                              input logic btn, input logic [31:0] stamp);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.quad_a <= a;
    in_ch.quad_b <= b;
    in_ch.button_pressed <= btn;
    in_ch.now_ms <= stamp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic sample_at(input logic [1:0] ab, input logic btn, input logic [31:0] stamp);
    pin_ab = ab;
    pin_btn = btn;
    now_ms = stamp;
    send_request(rei_pkg::MODE_SAMPLE, ab[1], ab[0], btn, stamp);
  endtask

  task automatic query(input logic [1:0] mode);
    send_request(mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), $urandom);
  endtask

  function automatic logic [1:0] next_ab(input logic [1:0] ab, input bit cw);
    logic [1:0] n;
    if (cw) begin
      case (ab)
        2'b01:   n = 2'b00;
        2'b00:   n = 2'b10;
        2'b10:   n = 2'b11;
        default: n = 2'b01;
      endcase
    end else begin
      case (ab)
        2'b00:   n = 2'b01;
        2'b10:   n = 2'b00;
        2'b11:   n = 2'b10;
        default: n = 2'b11;
      endcase
    end
    return n;
  endfunction

  task automatic write_register(input logic [rei_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [15:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [15:0] debounce, input logic [15:0] long_press);
    drain_results();
    write_register(ADDR_DEBOUNCE, debounce);
    write_register(ADDR_LONG_PRESS, long_press);
    cur_debounce = debounce;
    cur_long = long_press;
  endtask

  task automatic random_request(output bit counted);
    int          pick;
    logic [31:0] dt;
    counted = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 15) == 0) spin_cw = !spin_cw;
      sample_at(next_ab(pin_ab, spin_cw), pin_btn, now_ms + $urandom_range(0, 3));
    end else if (pick < 60) begin
      case ($urandom_range(0, 5))
        0:       dt = $urandom_range(0, cur_debounce);
        1:       dt = cur_debounce;
        2:       dt = cur_debounce + $urandom_range(0, cur_long);
        3:       dt = cur_long;
        4:       dt = cur_long + 1 + $urandom_range(0, 50);
        default: dt = $urandom_range(0, 70000);
      endcase
      sample_at(pin_ab, !pin_btn, now_ms + dt);
    end else if (pick < 72) begin
      query(rei_pkg::MODE_POLL);
    end else if (pick < 78) begin
      query(rei_pkg::MODE_READ);
    end else if (pick < 85) begin
      sample_at(pin_ab, pin_btn, now_ms + $urandom_range(0, 500));
    end else if (pick < 93) begin
      sample_at(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
    end else begin
      query(MODE_UNUSED);
      counted = 1'b0;
    end
  endtask

  task automatic random_phase(input int count);
    int n;
    bit counted;
    n = 0;
    while (n < count) begin
      random_request(counted);
      if (counted) n++;
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.mode <= rei_pkg::MODE_SAMPLE;
    in_ch.quad_a <= 1'b0;
    in_ch.quad_b <= 1'b1;
    in_ch.button_pressed <= 1'b0;
    in_ch.now_ms <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    query(rei_pkg::MODE_READ);
    query(rei_pkg::MODE_POLL);
    query(MODE_UNUSED);
    // one detent clockwise, then unchanged and invalid jumps
    sample_at(2'b00, 1'b0, 32'd10);
    sample_at(2'b10, 1'b0, 32'd10);
    sample_at(2'b11, 1'b0, 32'd11);
    sample_at(2'b01, 1'b0, 32'd12);
    sample_at(2'b01, 1'b0, 32'd13);
    sample_at(2'b10, 1'b0, 32'd14);
    sample_at(2'b01, 1'b0, 32'd15);
    query(rei_pkg::MODE_POLL);
    // one detent anticlockwise, count wraps below zero
    sample_at(2'b11, 1'b0, 32'd16);
    sample_at(2'b10, 1'b0, 32'd17);
    sample_at(2'b00, 1'b0, 32'd18);
    sample_at(2'b01, 1'b0, 32'd19);
    query(rei_pkg::MODE_POLL);
    // bounce, same-level edge, click and long click
    sample_at(2'b01, 1'b1, 32'd100);
    sample_at(2'b01, 1'b0, 32'd120);
    sample_at(2'b01, 1'b1, 32'd200);
    sample_at(2'b01, 1'b0, 32'd250);
    sample_at(2'b01, 1'b1, 32'd300);
    sample_at(2'b01, 1'b0, 32'd1301);
    query(rei_pkg::MODE_POLL);
    query(rei_pkg::MODE_POLL);
    // timestamp wrap
    sample_at(2'b01, 1'b1, 32'hFFFF_FFF0);
    sample_at(2'b01, 1'b0, 32'h0000_0020);

    // a few full turns clockwise at full rate
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    repeat (4 * BURST_TURNS) sample_at(next_ab(pin_ab, 1'b1), pin_btn, now_ms);
    query(rei_pkg::MODE_POLL);
    query(rei_pkg::MODE_READ);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;

    random_phase(ITEMS_PER_PHASE);
    reconfigure(16'd0, 16'd0);
    random_phase(ITEMS_PER_PHASE);
    reconfigure(16'hFFFF, 16'hFFFF);
    random_phase(ITEMS_PER_PHASE);
    reconfigure(16'($urandom_range(0, 200)), 16'($urandom_range(0, 3000)));
    random_phase(ITEMS_PER_PHASE);
    reconfigure(16'd7, 16'd120);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    random_phase(ITEMS_PER_PHASE);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
sv/rei_pkg.sv
sv/rei_in_if.sv
sv/rei_out_if.sv
sv/rei_cfg_regs.sv
sv/rei_quad.sv
sv/rei_switch.sv
sv/rotary_encoder_interface.sv
sim/rotary_encoder_interface_checker.sv
sim/rotary_encoder_interface_tb.sv
